@@ hdl/heat_diffusion_stencil_grid_defines.svh @@
// Assertion macros shared by the heat diffusion grid RTL
`ifndef HEAT_DIFFUSION_STENCIL_GRID_DEFINES_SVH
`define HEAT_DIFFUSION_STENCIL_GRID_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HDS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define HDS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define HDS_ASSERT_NOW(name, ante, cons)
`define HDS_ASSERT_NEXT(name, ante, cons)
`endif

`endif

@@ hdl/hds_pkg.sv @@
// Shared constants and types for the heat diffusion grid
`default_nettype none
package hds_pkg;

    localparam int INTERIOR_SIZE = 256;
    localparam int SIDE          = INTERIOR_SIZE + 2;
    localparam int CELLS         = SIDE * SIDE;
    localparam int HALF          = SIDE / 2;
    localparam int IDX_W         = $clog2(CELLS);
    localparam int ADDR_W        = IDX_W + 1;
    localparam int RC_W          = $clog2(SIDE);
    localparam int PADDR_W       = 4;
    localparam int RAD_W         = 64;
    localparam int ROOT_W        = 32;

    typedef logic [1:0] op_t;
    localparam op_t OP_WRITE = 2'd0;
    localparam op_t OP_RUN   = 2'd1;
    localparam op_t OP_READ  = 2'd2;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_GAIN    = 2'd0;
    localparam reg_idx_t REG_ITERS   = 2'd1;
    localparam reg_idx_t REG_HOT     = 2'd2;
    localparam reg_idx_t REG_HOT_EN  = 2'd3;

    localparam logic [23:0] GAIN_RST   = 24'd101855;
    localparam logic [15:0] ITERS_RST  = 16'd100;
    localparam logic [31:0] HOT_RST    = 32'd26214400;
    localparam logic        HOT_EN_RST = 1'b1;

endpackage
`default_nettype wire

@@ hdl/hds_in_if.sv @@
// Command channel carrying one grid operation per word
`default_nettype none
interface hds_in_if;
    logic               valid;
    logic               ready;
    hds_pkg::op_t       operation;
    logic [8:0]         row;
    logic [8:0]         column;
    logic [31:0]        temperature;
    logic signed [31:0] source_delta;

    modport source (output valid, operation, row, column, temperature, source_delta,
                    input ready);
    modport sink (input valid, operation, row, column, temperature, source_delta,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/hds_out_if.sv @@
// Result channel carrying one result word per command
`default_nettype none
interface hds_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] cell_value;
    logic [31:0] residual_magnitude;
    logic        clamped;

    modport source (output valid, cell_value, residual_magnitude, clamped, input ready);
    modport sink (input valid, cell_value, residual_magnitude, clamped, output ready);
endinterface
`default_nettype wire

@@ hdl/hds_isqrt.sv @@
// Bit-serial integer square root of the residual sum
`default_nettype none
module hds_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [hds_pkg::RAD_W-1:0]   radicand,
    output logic                        busy,
    output logic                        done,
    output logic [hds_pkg::ROOT_W-1:0]  root
);

    localparam int CNT_W = $clog2(hds_pkg::ROOT_W + 1);
    localparam logic [hds_pkg::RAD_W-1:0] TOP_BIT = {2'b01, {(hds_pkg::RAD_W-2){1'b0}}};

    logic                       busy_reg;
    logic                       done_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [hds_pkg::RAD_W-1:0]  v_reg;
    logic [hds_pkg::RAD_W-1:0]  res_reg;
    logic [hds_pkg::RAD_W-1:0]  bit_reg;
    logic [hds_pkg::RAD_W-1:0]  trial;
    logic                       fits;

    assign trial = res_reg + bit_reg;
    assign fits  = v_reg >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(hds_pkg::ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= TOP_BIT;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = res_reg[hds_pkg::ROOT_W-1:0];

endmodule
`default_nettype wire

@@ hdl/heat_diffusion_stencil_grid.sv @@
// Top level of the heat diffusion grid: memories, stencil sequencer and ports
// Write and read commands are taken one per cycle unless the result channel
// stalls; a read result is registered first in the memory read register, then
// in the output register. A run command walks the whole bordered grid once
// per diffusion step through the single read port of the grid memory: each
// interior cell passes through five stencil reads, a two-pass gain multiply,
// rounding, saturation and write-back, and each border cell is copied into
// the other bank. A closing residual pass follows, then the square root; no
// command is taken during a run. The grid is held twice (ping-pong banks), so
// all deltas of a step read the old grid.
`default_nettype none
`include "heat_diffusion_stencil_grid_defines.svh"
module heat_diffusion_stencil_grid (
    input  logic                          clk,
    input  logic                          rst_n,
    hds_in_if.sink                        in_ch,
    hds_out_if.source                     out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hds_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int IDX_W  = hds_pkg::IDX_W;
    localparam int ADDR_W = hds_pkg::ADDR_W;
    localparam int RC_W   = hds_pkg::RC_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WAIT = 3'd1;
    localparam logic [2:0] ST_CELL = 3'd2;
    localparam logic [2:0] ST_ROOT = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    localparam logic [3:0] PH_CTR   = 4'd0;
    localparam logic [3:0] PH_LEFT  = 4'd1;
    localparam logic [3:0] PH_RIGHT = 4'd2;
    localparam logic [3:0] PH_UP    = 4'd3;
    localparam logic [3:0] PH_DOWN  = 4'd4;
    localparam logic [3:0] PH_LAP   = 4'd5;
    localparam logic [3:0] PH_ABS   = 4'd6;
    localparam logic [3:0] PH_MLO   = 4'd7;
    localparam logic [3:0] PH_MHI   = 4'd8;
    localparam logic [3:0] PH_SIGN  = 4'd9;
    localparam logic [3:0] PH_DELTA = 4'd10;
    localparam logic [3:0] PH_UPD   = 4'd11;
    localparam logic [3:0] PH_ACC   = 4'd12;

    localparam logic [RC_W-1:0] LAST_RC = RC_W'(hds_pkg::SIDE - 1);
    localparam logic [RC_W-1:0] MID_LO  = RC_W'(hds_pkg::HALF);
    localparam logic [RC_W-1:0] MID_HI  = RC_W'(hds_pkg::HALF + 1);
    localparam logic [IDX_W-1:0] ROW_STRIDE = IDX_W'(hds_pkg::SIDE);
    localparam logic [ADDR_W-1:0] BANK_BASE = ADDR_W'(hds_pkg::CELLS);

    localparam logic signed [40:0] D_MAX = 41'sd2147483647;
    localparam logic signed [40:0] D_MIN = -41'sd2147483648;
    localparam logic signed [33:0] T_MAX = 34'sd4294967295;
    localparam logic signed [59:0] ROUND_HALF = 60'sd524288;

    // configuration
    logic [23:0] gain_reg;
    logic [15:0] iters_reg;
    logic [31:0] hot_temp_reg;
    logic        hot_en_reg;
    logic        cfg_we;

    // control
    logic [2:0]       state_reg;
    logic [3:0]       ph_reg;
    logic             bank_reg;
    logic             mode_res_reg;
    logic [15:0]      iter_reg;
    logic [RC_W-1:0]  row_reg;
    logic [RC_W-1:0]  col_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             s1_valid_reg;
    logic             s1_read_reg;
    logic             out_valid_reg;

    // datapath
    logic [31:0]        center_reg;
    logic [31:0]        src_reg;
    logic signed [35:0] acc_reg;
    logic               neg_reg;
    logic [33:0]        mag_reg;
    logic [57:0]        prod_reg;
    logic signed [59:0] p_reg;
    logic signed [31:0] d_reg;
    logic [63:0]        sq_reg;
    logic [63:0]        resid_reg;
    logic               sat_reg;
    logic [31:0]        cell_value_reg;
    logic [31:0]        resid_mag_reg;
    logic               clamped_reg;

    // memories
    logic [31:0]       grid_mem [2*hds_pkg::CELLS];
    logic [31:0]       src_mem  [hds_pkg::CELLS];
    logic [31:0]       grid_rdata_reg;
    logic [31:0]       src_rdata_reg;
    logic              grid_we;
    logic              grid_re;
    logic              grid_wbank;
    logic [IDX_W-1:0]  grid_widx;
    logic [IDX_W-1:0]  grid_ridx;
    logic [ADDR_W-1:0] grid_waddr;
    logic [ADDR_W-1:0] grid_raddr;
    logic [31:0]       grid_wdata;
    logic              src_we;
    logic              src_re;

    // combinational
    logic             in_fire;
    logic             in_inside;
    logic [IDX_W-1:0] in_idx;
    logic             out_free;
    logic             s1_load_out;
    logic             run_load_out;
    logic             cell_int;
    logic             centre;
    logic             last_col;
    logic             last_row;
    logic             in_cell;
    logic             cell_re;
    logic             cell_we;
    logic             advance;
    logic             pass_end;
    logic [IDX_W-1:0] cell_raddr;
    logic [16:0]      mul_in;
    logic [40:0]      mul_out;
    logic signed [59:0] p_round;
    logic signed [59:0] q_full;
    logic signed [40:0] d_sum;
    logic signed [31:0] d_sat;
    logic               d_clip;
    logic signed [33:0] t_sum;
    logic [31:0]        t_sat;
    logic               t_clip;
    logic [31:0]        d_abs;
    logic [64:0]        acc_sum;
    logic               sqrt_busy;
    logic               sqrt_done;
    logic [31:0]        sqrt_root;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            hds_pkg::REG_GAIN:   prdata = {8'd0, gain_reg};
            hds_pkg::REG_ITERS:  prdata = {16'd0, iters_reg};
            hds_pkg::REG_HOT:    prdata = hot_temp_reg;
            hds_pkg::REG_HOT_EN: prdata = {31'd0, hot_en_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= hds_pkg::GAIN_RST;
            iters_reg    <= hds_pkg::ITERS_RST;
            hot_temp_reg <= hds_pkg::HOT_RST;
            hot_en_reg   <= hds_pkg::HOT_EN_RST;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                hds_pkg::REG_GAIN:   gain_reg     <= pwdata[23:0];
                hds_pkg::REG_ITERS:  iters_reg    <= pwdata[15:0];
                hds_pkg::REG_HOT:    hot_temp_reg <= pwdata;
                hds_pkg::REG_HOT_EN: hot_en_reg   <= pwdata[0];
            endcase
        end
    end

    // command decode
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready  = (state_reg == ST_IDLE) && (!s1_valid_reg || out_free);
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign in_inside    = (32'(in_ch.row) < hds_pkg::SIDE) && (32'(in_ch.column) < hds_pkg::SIDE);
    assign in_idx       = IDX_W'(32'(in_ch.row) * hds_pkg::SIDE + 32'(in_ch.column));
    assign s1_load_out  = s1_valid_reg && out_free;
    assign run_load_out = (state_reg == ST_DONE) && out_free;

    // cell walk
    assign in_cell  = state_reg == ST_CELL;
    assign last_col = col_reg == LAST_RC;
    assign last_row = row_reg == LAST_RC;
    assign cell_int = (row_reg != '0) && !last_row && (col_reg != '0) && !last_col;
    assign centre   = ((row_reg == MID_LO) || (row_reg == MID_HI))
                   && ((col_reg == MID_LO) || (col_reg == MID_HI));
    assign pass_end = last_col && last_row;

    always_comb
    begin
        case (ph_reg)
            PH_LEFT:  cell_raddr = idx_reg - 1'b1;
            PH_RIGHT: cell_raddr = idx_reg + 1'b1;
            PH_UP:    cell_raddr = idx_reg - ROW_STRIDE;
            PH_DOWN:  cell_raddr = idx_reg + ROW_STRIDE;
            default:  cell_raddr = idx_reg;
        endcase
    end

    assign cell_re = in_cell
                  && (((ph_reg == PH_CTR) && (cell_int || !mode_res_reg))
                   || ((ph_reg >= PH_LEFT) && (ph_reg <= PH_DOWN) && cell_int));
    assign cell_we = in_cell && !mode_res_reg
                  && (((ph_reg == PH_LEFT) && !cell_int) || (ph_reg == PH_UPD));
    assign advance = in_cell
                  && (((ph_reg == PH_CTR) && mode_res_reg && !cell_int)
                   || ((ph_reg == PH_LEFT) && !mode_res_reg && !cell_int)
                   || ((ph_reg == PH_UPD) && !mode_res_reg)
                   || (ph_reg == PH_ACC));

    // arithmetic
    assign mul_in  = (ph_reg == PH_MHI) ? mag_reg[33:17] : mag_reg[16:0];
    assign mul_out = 41'(gain_reg) * 41'(mul_in);
    assign p_round = p_reg + ROUND_HALF;
    assign q_full  = p_round >>> 20;
    assign d_sum   = $signed(q_full[40:0]) + 41'($signed(src_reg));

    always_comb
    begin
        d_clip = 1'b1;
        if (d_sum > D_MAX)
            d_sat = 32'sh7fffffff;
        else if (d_sum < D_MIN)
            d_sat = 32'sh80000000;
        else
        begin
            d_sat  = d_sum[31:0];
            d_clip = 1'b0;
        end
    end

    assign t_sum = $signed({2'b00, center_reg}) + 34'(d_reg);

    always_comb
    begin
        t_clip = 1'b1;
        if (t_sum < 34'sd0)
            t_sat = 32'd0;
        else if (t_sum > T_MAX)
            t_sat = 32'hffffffff;
        else
        begin
            t_sat  = t_sum[31:0];
            t_clip = 1'b0;
        end
    end

    assign d_abs   = d_reg[31] ? 32'(-d_reg) : 32'(d_reg);
    assign acc_sum = {1'b0, resid_reg} + {1'b0, sq_reg};

    // memory ports
    assign src_we     = in_fire && (in_ch.operation == hds_pkg::OP_WRITE) && in_inside;
    assign src_re     = in_cell && (ph_reg == PH_CTR);
    assign grid_we    = src_we || cell_we;
    assign grid_re    = cell_re
                     || (in_fire && (in_ch.operation == hds_pkg::OP_READ) && in_inside);
    assign grid_wbank = in_cell ? !bank_reg : bank_reg;
    assign grid_widx  = in_cell ? idx_reg : in_idx;
    assign grid_ridx  = in_cell ? cell_raddr : in_idx;
    assign grid_waddr = {1'b0, grid_widx} + (grid_wbank ? BANK_BASE : '0);
    assign grid_raddr = {1'b0, grid_ridx} + (bank_reg ? BANK_BASE : '0);

    always_comb
    begin
        if (!in_cell)
            grid_wdata = in_ch.temperature;
        else if (ph_reg == PH_LEFT)
            grid_wdata = grid_rdata_reg;
        else if (hot_en_reg && centre)
            grid_wdata = hot_temp_reg;
        else
            grid_wdata = t_sat;
    end

    always_ff @(posedge clk)
    begin
        if (grid_we)
            grid_mem[grid_waddr] <= grid_wdata;
        if (grid_re)
            grid_rdata_reg <= grid_mem[grid_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (src_we)
            src_mem[in_idx] <= in_ch.source_delta;
        if (src_re)
            src_rdata_reg <= src_mem[idx_reg];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ph_reg        <= PH_CTR;
            bank_reg      <= 1'b0;
            mode_res_reg  <= 1'b0;
            iter_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s1_read_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire && (in_ch.operation != hds_pkg::OP_RUN))
            begin
                s1_valid_reg <= 1'b1;
                s1_read_reg  <= (in_ch.operation == hds_pkg::OP_READ) && in_inside;
            end
            else if (s1_load_out)
                s1_valid_reg <= 1'b0;

            if (s1_load_out || run_load_out)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && (in_ch.operation == hds_pkg::OP_RUN))
                        state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (!s1_valid_reg)
                    begin
                        state_reg    <= ST_CELL;
                        mode_res_reg <= iters_reg == '0;
                        iter_reg     <= iters_reg;
                        ph_reg       <= PH_CTR;
                        row_reg      <= '0;
                        col_reg      <= '0;
                        idx_reg      <= '0;
                    end
                end
                ST_CELL:
                begin
                    if (advance)
                    begin
                        ph_reg  <= PH_CTR;
                        idx_reg <= idx_reg + 1'b1;
                        if (last_col)
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + 1'b1;
                        end
                        else
                            col_reg <= col_reg + 1'b1;
                        if (pass_end)
                        begin
                            row_reg <= '0;
                            idx_reg <= '0;
                            if (mode_res_reg)
                                state_reg <= ST_ROOT;
                            else
                            begin
                                bank_reg <= !bank_reg;
                                iter_reg <= iter_reg - 1'b1;
                                if (iter_reg == 16'd1)
                                    mode_res_reg <= 1'b1;
                            end
                        end
                    end
                    else
                        ph_reg <= ph_reg + 1'b1;
                end
                ST_ROOT:
                    state_reg <= ST_SQRT;
                ST_SQRT:
                begin
                    if (sqrt_done)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_WAIT) && !s1_valid_reg)
        begin
            sat_reg   <= 1'b0;
            resid_reg <= '0;
        end

        if (in_cell)
        begin
            case (ph_reg)
                PH_LEFT:
                begin
                    center_reg <= grid_rdata_reg;
                    src_reg    <= src_rdata_reg;
                end
                PH_RIGHT: acc_reg <= $signed({4'd0, grid_rdata_reg});
                PH_UP:    acc_reg <= acc_reg + $signed({4'd0, grid_rdata_reg});
                PH_DOWN:  acc_reg <= acc_reg + $signed({4'd0, grid_rdata_reg});
                PH_LAP:   acc_reg <= acc_reg + $signed({4'd0, grid_rdata_reg})
                                   - $signed({2'd0, center_reg, 2'd0});
                PH_ABS:
                begin
                    neg_reg <= acc_reg[35];
                    mag_reg <= acc_reg[35] ? 34'(-acc_reg) : 34'(acc_reg);
                end
                PH_MLO:   prod_reg <= 58'(mul_out);
                PH_MHI:   prod_reg <= prod_reg + {mul_out, 17'd0};
                PH_SIGN:  p_reg <= neg_reg ? -$signed({2'd0, prod_reg})
                                           : $signed({2'd0, prod_reg});
                PH_DELTA:
                begin
                    d_reg <= d_sat;
                    if (d_clip)
                        sat_reg <= 1'b1;
                end
                PH_UPD:
                begin
                    if (mode_res_reg)
                        sq_reg <= 64'(d_abs) * 64'(d_abs);
                    else if (t_clip)
                        sat_reg <= 1'b1;
                end
                PH_ACC:
                begin
                    if (acc_sum[64])
                    begin
                        resid_reg <= '1;
                        sat_reg   <= 1'b1;
                    end
                    else
                        resid_reg <= acc_sum[63:0];
                end
                default:
                    center_reg <= center_reg;
            endcase
        end

        if (s1_load_out)
        begin
            cell_value_reg <= s1_read_reg ? grid_rdata_reg : 32'd0;
            resid_mag_reg  <= 32'd0;
            clamped_reg    <= 1'b0;
        end
        else if (run_load_out)
        begin
            cell_value_reg <= 32'd0;
            resid_mag_reg  <= sqrt_root;
            clamped_reg    <= sat_reg;
        end
    end

    hds_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_ROOT),
        .radicand (resid_reg),
        .busy     (sqrt_busy),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.cell_value         = cell_value_reg;
    assign out_ch.residual_magnitude = resid_mag_reg;
    assign out_ch.clamped            = clamped_reg;

    `HDS_ASSERT_NOW(a_ready_only_idle, in_ch.ready, state_reg == ST_IDLE)
    `HDS_ASSERT_NOW(a_step_writes_other_bank, grid_we && in_cell, grid_wbank != bank_reg)
    `HDS_ASSERT_NOW(a_run_without_pending_word, in_cell, !s1_valid_reg)
    `HDS_ASSERT_NEXT(a_root_starts_sqrt, state_reg == ST_ROOT, sqrt_busy && (state_reg == ST_SQRT))

endmodule
`default_nettype wire
